// ===== hw/rtl/dnb_pkg.sv =====
package dnb_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int DECAY_W   = 8;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int SUM_W     = CH_W + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [FW_W-1:0]    RESET_FRAME_WIDTH  = FW_W'(64);
  localparam logic [FH_W-1:0]    RESET_FRAME_HEIGHT = FH_W'(64);
  localparam logic [DECAY_W-1:0] RESET_DECAY        = DECAY_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DECAY        = 2'd2
  } cfg_reg_e;

  // Channel 0 is red, then green, blue and luminance.
  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  typedef struct packed {
    pix_t pix;
    logic two;
    logic last;
  } q_entry_t;

  function automatic logic [COL_W-1:0] last_col_of(logic [FW_W-1:0] fw);
    int unsigned w;
    w = int'(fw);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return COL_W'(w - 1);
  endfunction

  function automatic logic [FH_W-1:0] last_row_of(logic [FH_W-1:0] fh);
    logic [FH_W-1:0] h;
    h = (fh < FH_W'(3)) ? FH_W'(3) : fh;
    return h - FH_W'(1);
  endfunction

endpackage

// ===== hw/rtl/dnb_pix_if.sv =====
interface dnb_pix_if;
  logic                      valid;
  logic                      ready;
  logic [dnb_pkg::CH_W-1:0]  red_in;
  logic [dnb_pkg::CH_W-1:0]  green_in;
  logic [dnb_pkg::CH_W-1:0]  blue_in;
  logic [dnb_pkg::CH_W-1:0]  lum_in;

  modport source (output valid, red_in, green_in, blue_in, lum_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, lum_in, output ready);
endinterface

// ===== hw/rtl/dnb_res_if.sv =====
interface dnb_res_if;
  logic                      valid;
  logic                      ready;
  logic [dnb_pkg::CH_W-1:0]  red_out;
  logic [dnb_pkg::CH_W-1:0]  green_out;
  logic [dnb_pkg::CH_W-1:0]  blue_out;
  logic [dnb_pkg::CH_W-1:0]  lum_out;
  logic                      frame_end;

  modport source (output valid, red_out, green_out, blue_out, lum_out, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, lum_out, frame_end,
                  output ready);
endinterface

// ===== hw/rtl/dnb_cfg_if.sv =====
interface dnb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dnb_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [dnb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== hw/rtl/dnb_lane.sv =====
module dnb_lane (
  input  logic [dnb_pkg::CH_W-1:0]    top_px,
  input  logic [dnb_pkg::CH_W-1:0]    bot_px,
  input  logic [dnb_pkg::CH_W-1:0]    left_px,
  input  logic [dnb_pkg::CH_W-1:0]    right_px,
  input  logic [dnb_pkg::DECAY_W-1:0] decay,
  output logic [dnb_pkg::CH_W-1:0]    res
);
  import dnb_pkg::*;

  logic [SUM_W-1:0] sum;
  logic [CH_W-1:0]  avg;

  assign sum = SUM_W'(top_px) + SUM_W'(bot_px) + SUM_W'(left_px) + SUM_W'(right_px);
  assign avg = sum[SUM_W-1:2];

  always_comb begin
    if (avg > CH_W'(decay)) begin
      res = avg - CH_W'(decay);
    end else begin
      res = '0;
    end
  end

endmodule

// ===== hw/rtl/dnb_out_queue.sv =====
module dnb_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dnb_pkg::q_entry_t   push_ent,
  output logic                has_room,
  dnb_res_if.source           out_ch
);
  import dnb_pkg::*;

  q_entry_t   ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       phase_r;
  q_entry_t   head;
  logic       xfer;
  logic       pop;

  assign head     = ent_r[rd_ptr_r];
  assign has_room = (cnt_r != 2'd2);
  assign xfer     = out_ch.valid && out_ch.ready;
  // A word with a trailing zero-row word leaves the queue after its second word.
  assign pop      = xfer && (phase_r || !head.two);

  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.red_out   = phase_r ? '0 : head.pix[0];
  assign out_ch.green_out = phase_r ? '0 : head.pix[1];
  assign out_ch.blue_out  = phase_r ? '0 : head.pix[2];
  assign out_ch.lum_out   = phase_r ? '0 : head.pix[3];
  assign out_ch.frame_end = phase_r && head.last;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      phase_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
        phase_r  <= 1'b0;
      end else if (xfer) begin
        phase_r  <= 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/decaying_neighbour_blur.sv =====
// Streams a light map in raster order, one pixel per input word, and returns the
// map after one in-place decaying blur pass, one row behind the input. Row 0 gives
// no output; each later input word gives one output word, and each word of the last
// row gives a second one, the zero bottom row, with frame_end on the frame's final
// word. Away from the last row the block takes one pixel per clock unless the output
// stalls; on the last row each pixel sends two words through the single output port.
// The first output word of an input is valid at the earliest on the cycle after that
// input is accepted. Four channel
// lanes compute the average and decay in parallel, and two 1024 x 32 line memories
// hold the previous original and blurred rows; their read ports run one pixel ahead
// of the input, so there is no read stall. The line memories need no clearing after
// reset. Writing frame_width or frame_height restarts the frame; configure only
// while the block is idle.
module decaying_neighbour_blur (
  input  logic       clk,
  input  logic       rst_n,
  dnb_pix_if.sink    in_px,
  dnb_res_if.source  out_px,
  dnb_cfg_if.sink    cfg_wr
);
  import dnb_pkg::*;

  logic [COL_W-1:0]   last_col_r;
  logic [COL_W-1:0]   pen_col_r;
  logic [FH_W-1:0]    last_row_r;
  logic [DECAY_W-1:0] decay_r;

  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic [FH_W-1:0]    row_r;
  logic [FH_W-1:0]    row_nxt;
  pix_t               left_r;

  pix_t               in_line_mem  [MAX_WIDTH];
  pix_t               out_line_mem [MAX_WIDTH];
  pix_t               in_rd_r;
  pix_t               out_rd_r;
  logic [COL_W-1:0]   in_raddr;

  logic               accept;
  logic               cfg_wr_en;
  logic               geom_wr;
  logic               col_last;
  logic               row_first;
  logic               interior;
  logic               right_zero;
  pix_t               pix_in;
  pix_t               left_px;
  pix_t               right_px;
  pix_t               blur;
  pix_t               res_px;
  logic               out_we;
  pix_t               out_wdata;
  logic               q_room;
  logic               q_push;
  q_entry_t           q_ent;

  assign cfg_wr.ready = 1'b1;
  assign cfg_wr_en    = cfg_wr.valid && cfg_wr.ready;
  assign geom_wr      = cfg_wr_en && (cfg_wr.reg_index == REG_FRAME_WIDTH ||
                                      cfg_wr.reg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= last_col_of(RESET_FRAME_WIDTH);
      pen_col_r  <= last_col_of(RESET_FRAME_WIDTH) - COL_W'(1);
      last_row_r <= last_row_of(RESET_FRAME_HEIGHT);
      decay_r    <= RESET_DECAY;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr.reg_index)
        REG_FRAME_WIDTH: begin
          last_col_r <= last_col_of(FW_W'(cfg_wr.data));
          pen_col_r  <= last_col_of(FW_W'(cfg_wr.data)) - COL_W'(1);
        end
        REG_FRAME_HEIGHT: last_row_r <= last_row_of(FH_W'(cfg_wr.data));
        REG_DECAY:        decay_r    <= DECAY_W'(cfg_wr.data);
        default: ;
      endcase
    end
  end

  assign in_px.ready = q_room;
  assign accept      = in_px.valid && in_px.ready;
  assign pix_in      = {in_px.lum_in, in_px.blue_in, in_px.green_in, in_px.red_in};

  assign col_last  = (col_r == last_col_r);
  assign row_first = (row_r == '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? '0 : row_r + FH_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    if (geom_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The read ports follow the position of the next pixel, so the registered data
  // is ready when that pixel arrives. Read and write addresses never collide since
  // a row holds at least three pixels.
  assign in_raddr = col_nxt + COL_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      in_line_mem[col_r] <= pix_in;
    end
    in_rd_r <= in_line_mem[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_line_mem[col_r] <= out_wdata;
    end
    out_rd_r <= out_line_mem[col_nxt];
  end

  // Only rows two and later hold interior pixels of the output row above them.
  assign interior   = (row_r >= FH_W'(2)) && (col_r != '0) && !col_last;
  assign right_zero = (col_r == pen_col_r) && (row_r > FH_W'(2));
  assign left_px    = (col_r == COL_W'(1)) ? '0 : left_r;
  assign right_px   = right_zero ? '0 : in_rd_r;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    dnb_lane u_lane (
      .top_px   (out_rd_r[ch]),
      .bot_px   (pix_in[ch]),
      .left_px  (left_px[ch]),
      .right_px (right_px[ch]),
      .decay    (decay_r),
      .res      (blur[ch])
    );
  end

  assign res_px    = interior ? blur : '0;
  assign out_we    = accept && (row_first || interior);
  assign out_wdata = row_first ? pix_in : blur;

  always_ff @(posedge clk) begin
    if (accept && interior) begin
      left_r <= blur;
    end
  end

  assign q_push     = accept && !row_first;
  assign q_ent.pix  = res_px;
  assign q_ent.two  = (row_r == last_row_r);
  assign q_ent.last = col_last;

  dnb_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .has_room (q_room),
    .out_ch   (out_px)
  );

endmodule

// ===== hw/rtl/dnb_checker.sv =====
module dnb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [dnb_pkg::CH_W-1:0]  out_red,
  input logic [dnb_pkg::CH_W-1:0]  out_green,
  input logic [dnb_pkg::CH_W-1:0]  out_blue,
  input logic [dnb_pkg::CH_W-1:0]  out_lum,
  input logic                      out_frame_end
);

  // A stalled output word holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_red, out_green, out_blue, out_lum, out_frame_end}))
    else $error("output word changed while stalled");

  // The frame's final word belongs to the bottom border row, which is black.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |->
      out_red == '0 && out_green == '0 && out_blue == '0 && out_lum == '0)
    else $error("frame_end on a nonzero pixel");

  // With nothing buffered, the input side must be open.
  a_empty_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output queue is empty");

  // Reset empties the output queue.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind decaying_neighbour_blur dnb_checker u_dnb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_px.ready),
  .out_valid     (out_px.valid),
  .out_ready     (out_px.ready),
  .out_red       (out_px.red_out),
  .out_green     (out_px.green_out),
  .out_blue      (out_px.blue_out),
  .out_lum       (out_px.lum_out),
  .out_frame_end (out_px.frame_end)
);
